/* design/quadratic_fit_pos_vel_estimator_core_defines.svh */
// Assertion macros for the quadratic fit estimator checker.
`ifndef QUADRATIC_FIT_POS_VEL_ESTIMATOR_CORE_DEFINES_SVH
`define QUADRATIC_FIT_POS_VEL_ESTIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define QF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset.
`define QF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/qfpve_pkg.sv */
// Package: widths, result type and build-time weight functions for the quadratic fit.
`default_nettype none

package qfpve_pkg;

    localparam int SMP_W          = 16;
    localparam int POS_W          = 16;
    localparam int VEL_W          = 24;
    localparam int DIV_LAT        = 3;
    localparam int IN_DATA_W      = 32;
    localparam int OUT_DATA_W     = 80;
    localparam int OUT_USER_W     = 1;
    localparam int WINDOW_DEF     = 8;
    localparam int FRAME_RATE_DEF = 60;

    typedef struct packed {
        logic signed [VEL_W-1:0] fit_vel_y;
        logic signed [VEL_W-1:0] fit_vel_x;
        logic signed [POS_W-1:0] fit_pos_y;
        logic signed [POS_W-1:0] fit_pos_x;
    } result_t;

    function automatic longint qf_tap(int n, int k);
        return 2 * longint'(k) - longint'(n - 1);
    endfunction

    function automatic longint qf_s2(int n);
        longint acc;
        longint v;
        int k;
        acc = 0;
        for (k = 0; k < n; k++)
        begin
            v = qf_tap(n, k);
            acc = acc + v * v;
        end
        return acc;
    endfunction

    function automatic longint qf_s4(int n);
        longint acc;
        longint v;
        int k;
        acc = 0;
        for (k = 0; k < n; k++)
        begin
            v = qf_tap(n, k);
            acc = acc + v * v * v * v;
        end
        return acc;
    endfunction

    function automatic longint qf_det(int n);
        longint s2;
        s2 = qf_s2(n);
        return longint'(n) * qf_s4(n) - s2 * s2;
    endfunction

    function automatic longint qf_den(int n);
        return qf_det(n) * qf_s2(n);
    endfunction

    function automatic longint qf_pos_raw(int n, int k);
        longint s2;
        longint s4;
        longint d;
        longint v;
        longint v0;
        s2 = qf_s2(n);
        s4 = qf_s4(n);
        d  = qf_det(n);
        v  = qf_tap(n, k);
        v0 = longint'(n - 1);
        return s2 * (s4 - s2 * v * v) + s2 * v0 * v0 * (longint'(n) * v * v - s2)
               + d * v0 * v;
    endfunction

    function automatic longint qf_vel_raw(int n, int f, int k);
        longint s2;
        longint d;
        longint v;
        longint v0;
        s2 = qf_s2(n);
        d  = qf_det(n);
        v  = qf_tap(n, k);
        v0 = longint'(n - 1);
        return 2 * longint'(f) * (d * v + 2 * v0 * s2 * (longint'(n) * v * v - s2));
    endfunction

    function automatic longint qf_abs(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint qf_gcd(longint a, longint b);
        longint x;
        longint y;
        longint t;
        int sh;
        x  = a;
        y  = b;
        sh = 0;
        if (x == 0)
        begin
            return y;
        end
        if (y == 0)
        begin
            return x;
        end
        while (((x | y) & 64'sd1) == 0)
        begin
            x  = x >> 1;
            y  = y >> 1;
            sh = sh + 1;
        end
        while ((x & 64'sd1) == 0)
        begin
            x = x >> 1;
        end
        while (y != 0)
        begin
            while ((y & 64'sd1) == 0)
            begin
                y = y >> 1;
            end
            if (x > y)
            begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end
        return x << sh;
    endfunction

    function automatic longint qf_pos_gcd(int n);
        longint g;
        int k;
        g = qf_den(n);
        for (k = 0; k < n; k++)
        begin
            g = qf_gcd(g, qf_abs(qf_pos_raw(n, k)));
        end
        return g;
    endfunction

    function automatic longint qf_vel_gcd(int n, int f);
        longint g;
        int k;
        g = qf_den(n);
        for (k = 0; k < n; k++)
        begin
            g = qf_gcd(g, qf_abs(qf_vel_raw(n, f, k)));
        end
        return g;
    endfunction

    function automatic longint qf_pos_absmax(int n);
        longint m;
        int k;
        m = 1;
        for (k = 0; k < n; k++)
        begin
            if (qf_abs(qf_pos_raw(n, k)) > m)
            begin
                m = qf_abs(qf_pos_raw(n, k));
            end
        end
        return m;
    endfunction

    function automatic longint qf_vel_absmax(int n, int f);
        longint m;
        int k;
        m = 1;
        for (k = 0; k < n; k++)
        begin
            if (qf_abs(qf_vel_raw(n, f, k)) > m)
            begin
                m = qf_abs(qf_vel_raw(n, f, k));
            end
        end
        return m;
    endfunction

    function automatic int qf_bits(longint x);
        longint r;
        int b;
        r = x;
        b = 0;
        while (r > 0)
        begin
            r = r >> 1;
            b = b + 1;
        end
        if (b == 0)
        begin
            b = 1;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

/* design/quadratic_fit_pos_vel_estimator_core.sv */
// Top level: sample window, weight lanes, merge trees, rounding dividers and output skid.
// Path: sample window, lane products, adder tree, 3-stage divider, then output register.
// Throughput: one sample per cycle while the skid entry is empty (s_tready high).
// Output register plus one skid entry; s_tready falls only while the skid entry is full.
// Reset (async, active low) clears the sample window, fill count and all valid flags.
`default_nettype none

module quadratic_fit_pos_vel_estimator_core #(
    parameter int WINDOW     = qfpve_pkg::WINDOW_DEF,
    parameter int FRAME_RATE = qfpve_pkg::FRAME_RATE_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [15:0] sample_x, [31:16] sample_y
    input  wire logic [qfpve_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [15:0] fit_pos_x, [31:16] fit_pos_y, [55:32] fit_vel_x, [79:56] fit_vel_y
    output logic [qfpve_pkg::OUT_DATA_W-1:0]          m_tdata,
    // [0] window_full
    output logic [qfpve_pkg::OUT_USER_W-1:0]          m_tuser
);
    import qfpve_pkg::*;

    localparam int     LEVELS   = $clog2(WINDOW);
    localparam int     DEPTH    = LEVELS + DIV_LAT + 1;
    localparam int     CNT_W    = $clog2(WINDOW + 1);
    localparam longint POS_G    = qf_pos_gcd(WINDOW);
    localparam longint VEL_G    = qf_vel_gcd(WINDOW, FRAME_RATE);
    localparam longint POS_R    = qf_den(WINDOW) / POS_G;
    localparam longint VEL_R    = qf_den(WINDOW) / VEL_G;
    localparam longint POS_WMAX = qf_pos_absmax(WINDOW) / POS_G;
    localparam longint VEL_WMAX = qf_vel_absmax(WINDOW, FRAME_RATE) / VEL_G;
    localparam int     PW_W     = qf_bits(POS_WMAX) + 1;
    localparam int     VW_W     = qf_bits(VEL_WMAX) + 1;
    localparam int     PP_W     = SMP_W + PW_W;
    localparam int     VP_W     = SMP_W + VW_W;
    localparam int     PS_W     = PP_W + LEVELS;
    localparam int     VS_W     = VP_W + LEVELS;

    logic signed [SMP_W-1:0] hist_x_reg [WINDOW];
    logic signed [SMP_W-1:0] hist_y_reg [WINDOW];
    logic [CNT_W-1:0]        fill_cnt_reg;
    logic [CNT_W-1:0]        fill_cnt_next;
    logic [DEPTH:0]          vld_reg;
    logic [DEPTH:0]          full_reg;

    logic en;
    logic in_acc;

    logic signed [PP_W-1:0] pos_x_prod [WINDOW];
    logic signed [PP_W-1:0] pos_y_prod [WINDOW];
    logic signed [VP_W-1:0] vel_x_prod [WINDOW];
    logic signed [VP_W-1:0] vel_y_prod [WINDOW];

    logic signed [PS_W-1:0] pos_x_sum;
    logic signed [PS_W-1:0] pos_y_sum;
    logic signed [VS_W-1:0] vel_x_sum;
    logic signed [VS_W-1:0] vel_y_sum;

    result_t pipe_data;
    logic    pipe_vld;

    result_t                 out_data_reg;
    result_t                 out_data_next;
    logic                    out_vld_reg;
    logic                    out_vld_next;
    logic [OUT_USER_W-1:0]   out_user_reg;
    logic [OUT_USER_W-1:0]   out_user_next;
    result_t                 skid_data_reg;
    result_t                 skid_data_next;
    logic                    skid_vld_reg;
    logic                    skid_vld_next;
    logic [OUT_USER_W-1:0]   skid_user_reg;
    logic [OUT_USER_W-1:0]   skid_user_next;

    assign en       = !skid_vld_reg;
    assign s_tready = en;
    assign in_acc   = s_tvalid && en;

    assign fill_cnt_next = (fill_cnt_reg == CNT_W'(WINDOW)) ? fill_cnt_reg
                                                             : fill_cnt_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WINDOW; k++)
            begin
                hist_x_reg[k] <= '0;
                hist_y_reg[k] <= '0;
            end
            fill_cnt_reg <= '0;
            vld_reg      <= '0;
            full_reg     <= '0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[DEPTH-1:0], in_acc};
            full_reg <= {full_reg[DEPTH-1:0], (fill_cnt_next == CNT_W'(WINDOW))};
            if (in_acc)
            begin
                for (int k = 0; k < WINDOW - 1; k++)
                begin
                    hist_x_reg[k] <= hist_x_reg[k+1];
                    hist_y_reg[k] <= hist_y_reg[k+1];
                end
                hist_x_reg[WINDOW-1] <= s_tdata[SMP_W-1:0];
                hist_y_reg[WINDOW-1] <= s_tdata[2*SMP_W-1:SMP_W];
                fill_cnt_reg         <= fill_cnt_next;
            end
        end
    end

    for (genvar k = 0; k < WINDOW; k++)
    begin : g_lane
        qfpve_lane #(
            .WINDOW     (WINDOW),
            .FRAME_RATE (FRAME_RATE),
            .TAP        (k),
            .POS_G      (POS_G),
            .VEL_G      (VEL_G),
            .PW_W       (PW_W),
            .VW_W       (VW_W)
        ) u_lane (
            .clk        (clk),
            .en         (en),
            .smp_x      (hist_x_reg[k]),
            .smp_y      (hist_y_reg[k]),
            .pos_x_prod (pos_x_prod[k]),
            .pos_y_prod (pos_y_prod[k]),
            .vel_x_prod (vel_x_prod[k]),
            .vel_y_prod (vel_y_prod[k])
        );
    end

    qfpve_merge #(.N(WINDOW), .IN_W(PP_W), .OUT_W(PS_W)) u_merge_pos_x (
        .clk (clk), .en (en), .term (pos_x_prod), .total (pos_x_sum)
    );
    qfpve_merge #(.N(WINDOW), .IN_W(PP_W), .OUT_W(PS_W)) u_merge_pos_y (
        .clk (clk), .en (en), .term (pos_y_prod), .total (pos_y_sum)
    );
    qfpve_merge #(.N(WINDOW), .IN_W(VP_W), .OUT_W(VS_W)) u_merge_vel_x (
        .clk (clk), .en (en), .term (vel_x_prod), .total (vel_x_sum)
    );
    qfpve_merge #(.N(WINDOW), .IN_W(VP_W), .OUT_W(VS_W)) u_merge_vel_y (
        .clk (clk), .en (en), .term (vel_y_prod), .total (vel_y_sum)
    );

    qfpve_rdiv #(.NUM_W(PS_W), .OUT_W(POS_W), .DIVISOR(POS_R)) u_rdiv_pos_x (
        .clk (clk), .en (en), .num (pos_x_sum), .res (pipe_data.fit_pos_x)
    );
    qfpve_rdiv #(.NUM_W(PS_W), .OUT_W(POS_W), .DIVISOR(POS_R)) u_rdiv_pos_y (
        .clk (clk), .en (en), .num (pos_y_sum), .res (pipe_data.fit_pos_y)
    );
    qfpve_rdiv #(.NUM_W(VS_W), .OUT_W(VEL_W), .DIVISOR(VEL_R)) u_rdiv_vel_x (
        .clk (clk), .en (en), .num (vel_x_sum), .res (pipe_data.fit_vel_x)
    );
    qfpve_rdiv #(.NUM_W(VS_W), .OUT_W(VEL_W), .DIVISOR(VEL_R)) u_rdiv_vel_y (
        .clk (clk), .en (en), .num (vel_y_sum), .res (pipe_data.fit_vel_y)
    );

    assign pipe_vld = vld_reg[DEPTH];

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_vld_next   = out_vld_reg;
        out_user_next  = out_user_reg;
        skid_data_next = skid_data_reg;
        skid_vld_next  = skid_vld_reg;
        skid_user_next = skid_user_reg;
        if (skid_vld_reg)
        begin
            if (m_tready)
            begin
                out_data_next = skid_data_reg;
                out_user_next = skid_user_reg;
                skid_vld_next = 1'b0;
            end
        end
        else if (pipe_vld)
        begin
            if (!out_vld_reg || m_tready)
            begin
                out_data_next = pipe_data;
                out_user_next = OUT_USER_W'(full_reg[DEPTH]);
                out_vld_next  = 1'b1;
            end
            else
            begin
                skid_data_next = pipe_data;
                skid_user_next = OUT_USER_W'(full_reg[DEPTH]);
                skid_vld_next  = 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

/* design/qfpve_lane.sv */
// One tap lane: multiplies a stored x/y sample by its fixed position and velocity weights.
`default_nettype none

module qfpve_lane #(
    parameter int     WINDOW     = qfpve_pkg::WINDOW_DEF,
    parameter int     FRAME_RATE = qfpve_pkg::FRAME_RATE_DEF,
    parameter int     TAP        = 0,
    parameter longint POS_G      = 1,
    parameter longint VEL_G      = 1,
    parameter int     PW_W       = 8,
    parameter int     VW_W       = 8
) (
    input  wire logic                                     clk,
    input  wire logic                                     en,
    input  wire logic signed [qfpve_pkg::SMP_W-1:0]       smp_x,
    input  wire logic signed [qfpve_pkg::SMP_W-1:0]       smp_y,
    output logic signed [qfpve_pkg::SMP_W+PW_W-1:0]       pos_x_prod,
    output logic signed [qfpve_pkg::SMP_W+PW_W-1:0]       pos_y_prod,
    output logic signed [qfpve_pkg::SMP_W+VW_W-1:0]       vel_x_prod,
    output logic signed [qfpve_pkg::SMP_W+VW_W-1:0]       vel_y_prod
);
    import qfpve_pkg::*;

    localparam int     PP_W  = SMP_W + PW_W;
    localparam int     VP_W  = SMP_W + VW_W;
    localparam longint PW_L  = qf_pos_raw(WINDOW, TAP) / POS_G;
    localparam longint VW_L  = qf_vel_raw(WINDOW, FRAME_RATE, TAP) / VEL_G;
    localparam logic signed [PW_W-1:0] PWGT = PW_W'(PW_L);
    localparam logic signed [VW_W-1:0] VWGT = VW_W'(VW_L);

    logic signed [PP_W-1:0] pos_x_reg;
    logic signed [PP_W-1:0] pos_y_reg;
    logic signed [VP_W-1:0] vel_x_reg;
    logic signed [VP_W-1:0] vel_y_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_x_reg <= PP_W'(smp_x) * PP_W'(PWGT);
            pos_y_reg <= PP_W'(smp_y) * PP_W'(PWGT);
            vel_x_reg <= VP_W'(smp_x) * VP_W'(VWGT);
            vel_y_reg <= VP_W'(smp_y) * VP_W'(VWGT);
        end
    end

    assign pos_x_prod = pos_x_reg;
    assign pos_y_prod = pos_y_reg;
    assign vel_x_prod = vel_x_reg;
    assign vel_y_prod = vel_y_reg;

endmodule

`default_nettype wire

/* design/qfpve_merge.sv */
// Registered adder tree that merges the lane products into one tap sum.
`default_nettype none

module qfpve_merge #(
    parameter int N     = qfpve_pkg::WINDOW_DEF,
    parameter int IN_W  = 24,
    parameter int OUT_W = 27
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [IN_W-1:0]  term [N],
    output logic signed [OUT_W-1:0]      total
);
    localparam int LEVELS = $clog2(N);

    logic signed [OUT_W-1:0] node [LEVELS+1][N];

    for (genvar l = 0; l <= LEVELS; l++)
    begin : g_lvl
        localparam int CNT  = (N + (1 << l) - 1) >> l;
        localparam int PREV = (l == 0) ? N : ((N + (1 << (l - 1)) - 1) >> (l - 1));
        for (genvar i = 0; i < N; i++)
        begin : g_node
            if (l == 0)
            begin : g_leaf
                assign node[l][i] = OUT_W'(term[i]);
            end
            else if (i < CNT)
            begin : g_add
                logic signed [OUT_W-1:0] sum_reg;
                if (2 * i + 1 < PREV)
                begin : g_pair
                    always_ff @(posedge clk)
                    begin
                        if (en)
                        begin
                            sum_reg <= node[l-1][2*i] + node[l-1][2*i+1];
                        end
                    end
                end
                else
                begin : g_single
                    always_ff @(posedge clk)
                    begin
                        if (en)
                        begin
                            sum_reg <= node[l-1][2*i];
                        end
                    end
                end
                assign node[l][i] = sum_reg;
            end
            else
            begin : g_none
                assign node[l][i] = '0;
            end
        end
    end

    assign total = node[LEVELS][0];

endmodule

`default_nettype wire

/* design/qfpve_rdiv.sv */
// Three-stage division by a constant through a reciprocal multiply: round half away, saturate.
`default_nettype none

module qfpve_rdiv #(
    parameter int     NUM_W   = 27,
    parameter int     OUT_W   = 16,
    parameter longint DIVISOR = 1
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [NUM_W-1:0]  num,
    output logic signed [OUT_W-1:0]       res
);
    import qfpve_pkg::*;

    localparam longint D2    = 2 * DIVISOR;
    localparam int     D2_W  = qf_bits(D2);
    localparam int     X_W   = qf_bits((longint'(1) << NUM_W) + DIVISOR);
    localparam int     SH    = X_W + D2_W;
    localparam longint RECIP = ((longint'(1) << SH) + D2 - 1) / D2;
    localparam int     M_W   = qf_bits(RECIP);
    localparam int     P_W   = X_W + M_W;
    localparam int     Q_W   = P_W - SH;
    localparam int     C_W   = (Q_W > OUT_W) ? Q_W : (OUT_W + 1);
    localparam logic [X_W-1:0] DIV_V   = X_W'(DIVISOR);
    localparam logic [M_W-1:0] RECIP_V = M_W'(RECIP);
    localparam logic [C_W-1:0] HI_C    = C_W'((longint'(1) << (OUT_W - 1)) - 1);
    localparam logic [C_W-1:0] LO_C    = HI_C + C_W'(1);

    logic [NUM_W-1:0] mag;
    logic [X_W-1:0]   x_next;
    logic [X_W-1:0]   x_reg;
    logic             sgn_x_reg;
    logic [P_W-1:0]   prod_reg;
    logic             sgn_p_reg;
    logic [C_W-1:0]   quo;
    logic [OUT_W-1:0] sat_next;
    logic [OUT_W-1:0] res_reg;

    assign mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign x_next = (X_W'(mag) << 1) + DIV_V;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            sgn_x_reg <= num[NUM_W-1];
            prod_reg  <= P_W'(x_reg) * P_W'(RECIP_V);
            sgn_p_reg <= sgn_x_reg;
            res_reg   <= sat_next;
        end
    end

    assign quo = C_W'(prod_reg[P_W-1:SH]);

    always_comb
    begin
        if (!sgn_p_reg)
        begin
            if (quo > HI_C)
            begin
                sat_next = {1'b0, {(OUT_W-1){1'b1}}};
            end
            else
            begin
                sat_next = quo[OUT_W-1:0];
            end
        end
        else
        begin
            if (quo > LO_C)
            begin
                sat_next = {1'b1, {(OUT_W-1){1'b0}}};
            end
            else
            begin
                sat_next = OUT_W'(0) - quo[OUT_W-1:0];
            end
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* design/qfpve_checker.sv */
// Port checker for the quadratic fit estimator, bound to the top level.
`default_nettype none
`include "quadratic_fit_pos_vel_estimator_core_defines.svh"

module qfpve_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_tvalid,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [qfpve_pkg::OUT_DATA_W-1:0]     m_tdata,
    input wire logic [qfpve_pkg::OUT_USER_W-1:0]     m_tuser
);
    import qfpve_pkg::*;

    logic seen_full_reg;
    logic any_in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_full_reg <= 1'b0;
            any_in_reg    <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready && m_tuser[0])
            begin
                seen_full_reg <= 1'b1;
            end
            if (s_tvalid && s_tready)
            begin
                any_in_reg <= 1'b1;
            end
        end
    end

    `QF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result request dropped while stalled")
    `QF_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result request changed while stalled")
    `QF_ASSERT_NOW(a_stall_cause, !s_tready, m_tvalid, "input stalled with no result waiting")
    `QF_ASSERT_NOW(a_full_sticky, m_tvalid && seen_full_reg, m_tuser[0], "window full flag fell")
    `QF_ASSERT_NOW(a_no_phantom, m_tvalid, any_in_reg, "result shown before any input request")

endmodule

bind quadratic_fit_pos_vel_estimator_core qfpve_checker u_qfpve_checker (.*);

`default_nettype wire

/* tb/sv/qfpve_fit_checker.sv */
// Checker for the quadratic fit estimator: predicts each fit from accepted samples and compares.
`timescale 1ns / 1ps

module qfpve_fit_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [qfpve_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [qfpve_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic [qfpve_pkg::OUT_USER_W-1:0]     m_tuser,
    output int                                   mismatches,
    output int                                   outstanding
);

    localparam int WIN  = qfpve_pkg::WINDOW_DEF;
    localparam int RATE = qfpve_pkg::FRAME_RATE_DEF;
    localparam int SHOW_MAX = 50;

    typedef logic signed [qfpve_pkg::SMP_W-1:0] sample_t;
    typedef sample_t sample_win_t [WIN];

    typedef struct packed {
        qfpve_pkg::result_t fit;
        logic               full;
    } fit_expect_t;

    sample_win_t   track_x;
    sample_win_t   track_y;
    int            samples_seen;
    int            shown;
    fit_expect_t   pending_fits[$];

    // round to nearest, ties away from zero, of num * mul / den
    function automatic longint round_scaled(longint num, longint mul, longint den);
        longint mag;
        longint q;
        longint r;
        longint res;
        mag = (num < 0) ? -num : num;
        q   = mag / den;
        r   = mag % den;
        res = q * mul + (2 * mul * r + den) / (2 * den);
        if (res > (longint'(1) <<< 40))
        begin
            res = longint'(1) <<< 40;
        end
        return (num < 0) ? -res : res;
    endfunction

    function automatic longint clamp_bits(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function automatic void fit_endpoint(input sample_win_t h,
                                         output logic signed [qfpve_pkg::POS_W-1:0] pos,
                                         output logic signed [qfpve_pkg::VEL_W-1:0] vel);
        longint s0;
        longint s2;
        longint s4;
        longint d;
        longint v0;
        longint v;
        longint y0;
        longint y1;
        longint y2;
        longint curv;
        longint pnum;
        longint vnum;
        longint den;
        longint pclamp;
        longint vclamp;
        s0 = WIN;
        v0 = WIN - 1;
        s2 = 0;
        s4 = 0;
        y0 = 0;
        y1 = 0;
        y2 = 0;
        for (int k = 0; k < WIN; k++)
        begin
            v  = 2 * longint'(k) - v0;
            s2 = s2 + v * v;
            s4 = s4 + v * v * v * v;
            y0 = y0 + longint'(h[k]);
            y1 = y1 + v * longint'(h[k]);
            y2 = y2 + v * v * longint'(h[k]);
        end
        d      = s0 * s4 - s2 * s2;
        curv   = s0 * y2 - s2 * y0;
        pnum   = s2 * (s4 * y0 - s2 * y2) + s2 * v0 * v0 * curv + d * v0 * y1;
        vnum   = d * y1 + 2 * v0 * s2 * curv;
        den    = d * s2;
        pclamp = clamp_bits(round_scaled(pnum, 1, den), qfpve_pkg::POS_W);
        vclamp = clamp_bits(round_scaled(vnum, 2 * RATE, den), qfpve_pkg::VEL_W);
        pos    = pclamp[qfpve_pkg::POS_W-1:0];
        vel    = vclamp[qfpve_pkg::VEL_W-1:0];
    endfunction

    function automatic int field_differs(string name, longint want, longint got);
        if (want != got)
        begin
            if (shown < SHOW_MAX)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                shown = shown + 1;
            end
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        fit_expect_t        want;
        fit_expect_t        next_fit;
        qfpve_pkg::result_t got;
        int                 bad;
        if (!rst_n)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                track_x[k] = '0;
                track_y[k] = '0;
            end
            samples_seen = 0;
            shown        = 0;
            mismatches   = 0;
            outstanding  = 0;
            pending_fits.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = qfpve_pkg::result_t'(m_tdata);
                if (pending_fits.size() == 0)
                begin
                    if (shown < SHOW_MAX)
                    begin
                        $display("%0t: result with no sample pending, expected none actual %h",
                                 $time, m_tdata);
                        shown = shown + 1;
                    end
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = pending_fits.pop_front();
                    bad  = field_differs("fit_pos_x", want.fit.fit_pos_x, got.fit_pos_x);
                    bad += field_differs("fit_pos_y", want.fit.fit_pos_y, got.fit_pos_y);
                    bad += field_differs("fit_vel_x", want.fit.fit_vel_x, got.fit_vel_x);
                    bad += field_differs("fit_vel_y", want.fit.fit_vel_y, got.fit_vel_y);
                    bad += field_differs("window_full", want.full, m_tuser[0]);
                    mismatches = mismatches + bad;
                end
            end
            if (s_tvalid && s_tready)
            begin
                for (int k = 0; k < WIN - 1; k++)
                begin
                    track_x[k] = track_x[k + 1];
                    track_y[k] = track_y[k + 1];
                end
                track_x[WIN - 1] = s_tdata[15:0];
                track_y[WIN - 1] = s_tdata[31:16];
                if (samples_seen < WIN)
                begin
                    samples_seen = samples_seen + 1;
                end
                fit_endpoint(track_x, next_fit.fit.fit_pos_x, next_fit.fit.fit_vel_x);
                fit_endpoint(track_y, next_fit.fit.fit_pos_y, next_fit.fit.fit_vel_y);
                next_fit.full = (samples_seen >= WIN);
                pending_fits.insert(pending_fits.size(), next_fit);
            end
            outstanding = pending_fits.size();
        end
    end

endmodule

/* tb/sv/tb_quadratic_fit_pos_vel_estimator_core.sv */
// Testbench top for the quadratic fit estimator: clock, reset, sample stimulus, sink and verdict.
`timescale 1ns / 1ps

module tb_quadratic_fit_pos_vel_estimator_core;

    localparam int RANDOM_CHUNKS = 4;
    localparam int CHUNK_ITEMS   = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 4000;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  s_tvalid;
    logic                                  s_tready;
    logic [qfpve_pkg::IN_DATA_W-1:0]       s_tdata;
    logic                                  m_tvalid;
    logic                                  m_tready;
    logic [qfpve_pkg::OUT_DATA_W-1:0]      m_tdata;
    logic [qfpve_pkg::OUT_USER_W-1:0]      m_tuser;

    int   mismatches;
    int   outstanding;
    bit   src_idle;
    bit   snk_idle;
    bit   hold_req;
    int   path_x;
    int   path_y;
    int   path_vx;
    int   path_vy;
    int   quiet_cycles;

    quadratic_fit_pos_vel_estimator_core u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    qfpve_fit_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic int bound_speed(int v);
        if (v > 3000)
        begin
            return 3000;
        end
        if (v < -3000)
        begin
            return -3000;
        end
        return v;
    endfunction

    task automatic send_sample(input logic [15:0] x, input logic [15:0] y);
        int gap;
        gap = src_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random();
        logic [15:0] x;
        logic [15:0] y;
        int          pick;
        pick = $urandom_range(0, 7);
        if (pick == 7)
        begin
            path_x  = $signed(16'($urandom()));
            path_y  = $signed(16'($urandom()));
            path_vx = $urandom_range(0, 4000) - 2000;
            path_vy = $urandom_range(0, 4000) - 2000;
        end
        if (pick <= 4 || pick == 7)
        begin
            path_vx = bound_speed(path_vx + $urandom_range(0, 64) - 32);
            path_vy = bound_speed(path_vy + $urandom_range(0, 64) - 32);
            path_x  = path_x + path_vx;
            path_y  = path_y + path_vy;
            x = path_x[15:0];
            y = path_y[15:0];
        end
        else if (pick == 5)
        begin
            x = 16'($urandom());
            y = 16'($urandom());
        end
        else
        begin
            x = pick_extreme();
            y = pick_extreme();
        end
        send_sample(x, y);
    endtask

    // sink: per-result ready gaps, plus one long hold-off on request
    initial
    begin : sink
        int gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = snk_idle ? $urandom_range(0, 9) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
        $display("quadratic_fit_pos_vel_estimator_core: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        src_idle = 1'b0;
        snk_idle = 1'b0;
        hold_req = 1'b0;
        path_x   = 0;
        path_y   = 0;
        path_vx  = 100;
        path_vy  = -100;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the window from zero with the extremes, then flip and jump
        repeat (8) send_sample(16'h7FFF, 16'h8000);
        repeat (2)
        begin
            send_sample(16'h8000, 16'h7FFF);
            send_sample(16'h7FFF, 16'h8000);
        end
        repeat (4) send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'hFFFF, 16'h0000);
        send_sample(16'h0001, 16'h8001);
        send_sample(16'h5555, 16'hAAAA);
        send_sample(16'hAAAA, 16'h5555);

        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++)
        begin
            case (chunk)
                0:
                begin
                    src_idle = 1'b1;
                    snk_idle = 1'b1;
                end
                1:
                begin
                    src_idle = 1'b0;
                    snk_idle = 1'b0;
                    hold_req = 1'b1;
                end
                2:
                begin
                    src_idle = 1'b1;
                    snk_idle = 1'b0;
                end
                default:
                begin
                    src_idle = 1'b0;
                    snk_idle = 1'b1;
                end
            endcase
            repeat (CHUNK_ITEMS) send_random();
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("quadratic_fit_pos_vel_estimator_core: match");
        end
        else
        begin
            $display("quadratic_fit_pos_vel_estimator_core: mismatch");
        end
        $finish;
    end

endmodule
